FILE: sv/torus_xy_route_hops_unit_macros.svh
// Assertion macros shared by the route unit RTL
`ifndef TORUS_XY_ROUTE_HOPS_UNIT_MACROS_SVH
`define TORUS_XY_ROUTE_HOPS_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TXYR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("txyr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TXYR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("txyr assertion failed");

`endif

FILE: sv/txyr_pkg.sv
// Shared types and constants of the torus XY route unit
`timescale 1ns / 1ps

package txyr_pkg;

    localparam int ID_W  = 10;
    localparam int CFG_W = 6;

    localparam logic [CFG_W-1:0] TORUS_SIDE_RST = 6'd4;

    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_DIV_SRC,
        ST_DIV_DST,
        ST_WALK_X,
        ST_WALK_Y
    } t_state;

endpackage

FILE: sv/txyr_if.sv
// Channel interfaces of the torus XY route unit
`timescale 1ns / 1ps

interface txyr_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [txyr_pkg::CFG_W-1:0] torus_side;

    modport source (output valid, output torus_side, input ready);
    modport sink   (input valid, input torus_side, output ready);
endinterface

interface txyr_req_if;
    logic                     valid;
    logic                     ready;
    logic [txyr_pkg::ID_W-1:0] source_node;
    logic [txyr_pkg::ID_W-1:0] target_node;

    modport source (output valid, output source_node, output target_node, input ready);
    modport sink   (input valid, input source_node, input target_node, output ready);
endinterface

interface txyr_hop_if;
    logic                     valid;
    logic                     ready;
    logic [txyr_pkg::ID_W-1:0] hop_from;
    logic [txyr_pkg::ID_W-1:0] hop_to;
    logic                     hop_dim;
    logic                     hop_positive;
    logic                     no_hop;
    logic                     bad_id;
    logic                     last_hop;

    modport source (output valid, output hop_from, output hop_to, output hop_dim,
                    output hop_positive, output no_hop, output bad_id, output last_hop,
                    input ready);
    modport sink   (input valid, input hop_from, input hop_to, input hop_dim,
                    input hop_positive, input no_hop, input bad_id, input last_hop,
                    output ready);
endinterface

FILE: sv/txyr_divider.sv
// Bit-serial restoring divider that splits a node id into row and column
`timescale 1ns / 1ps
`include "torus_xy_route_hops_unit_macros.svh"

module txyr_divider #(
    parameter int CW = 5,
    parameter int SW = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [txyr_pkg::ID_W-1:0] i_dividend,
    input  logic [SW-1:0]             i_divisor,
    output logic                      o_done,
    output logic [CW-1:0]             o_quotient,
    output logic [CW-1:0]             o_remainder
);

    logic [txyr_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [txyr_pkg::ID_W-1:0]      r_dvd;
    logic [CW-1:0]                  r_rem;
    logic [CW-1:0]                  r_quo;
    logic [SW-1:0]                  r_dsr;

    logic [CW:0]   w_shift;
    logic [CW+1:0] w_trial;
    logic          w_take;

    always_comb begin
        w_shift = {r_rem, r_dvd[txyr_pkg::ID_W-1]};
        w_trial = {1'b0, w_shift} - (CW+2)'(r_dsr);
        w_take  = ~w_trial[CW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= txyr_pkg::DIV_STEPS;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == txyr_pkg::DIV_CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - txyr_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[txyr_pkg::ID_W-2:0], 1'b0};
            r_rem <= w_take ? w_trial[CW-1:0] : w_shift[CW-1:0];
            r_quo <= CW'({r_quo, w_take});
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `TXYR_ASSERT_NOW(a_start_when_free, i_clk, i_rst_n, i_start, r_cnt == '0)
    `TXYR_ASSERT_NOW(a_done_after_count, i_clk, i_rst_n, r_done, r_cnt == '0)
    `TXYR_ASSERT_NEXT(a_start_loads_count, i_clk, i_rst_n, i_start,
        r_cnt == txyr_pkg::DIV_STEPS)

endmodule

FILE: sv/torus_xy_route_hops_unit.sv
// Top level: dimension-order XY route on a square 2D torus, one hop per transaction
//
// Channels: i_cfg writes the torus side (always ready, write only while idle);
// i_req takes a source and target node id; o_hop returns the hops of the route
// in order, X along the source row first, then Y along the target column, each
// in the shorter ring direction, with last_hop on the final one.
// An id not below side squared gives one transaction with bad_id set; equal
// ids give one transaction with no_hop set. A side above MAX_SIDE saturates.
// Order: a special case goes from ST_SINGLE into the output register; otherwise
// the shared bit-serial divider splits source then target id, and then the walk
// gives one hop a cycle while o_hop does not stall, with no hop in the state that
// turns from X to Y. One request at a time: i_req.ready is low while a route is
// in flight.
// When o_hop stalls, the output register holds and the walk waits.
// Reset: side returns to 4, the sequencer to idle, o_hop.valid drops.
`timescale 1ns / 1ps
`include "torus_xy_route_hops_unit_macros.svh"

module torus_xy_route_hops_unit #(
    parameter int MAX_SIDE = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    txyr_cfg_if.sink   i_cfg,
    txyr_req_if.sink   i_req,
    txyr_hop_if.source o_hop
);

    localparam int IW   = txyr_pkg::ID_W;
    localparam int CW   = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int SQW  = 2 * SW;
    localparam int CMPW = (SQW > IW) ? SQW : IW;

    txyr_pkg::t_state r_state, n_state;

    logic [txyr_pkg::CFG_W-1:0] r_torus_side;

    logic [IW-1:0] r_src, n_src;
    logic [IW-1:0] r_dst, n_dst;
    logic          r_bad, n_bad;
    logic [CW-1:0] r_cur_row, n_cur_row;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [CW-1:0] r_goal_row, n_goal_row;
    logic [CW-1:0] r_goal_col, n_goal_col;
    logic          r_dir, n_dir;
    logic [IW-1:0] r_base, n_base;

    logic          r_out_valid, n_out_valid;
    logic [IW-1:0] r_out_from, n_out_from;
    logic [IW-1:0] r_out_to, n_out_to;
    logic          r_out_dim, n_out_dim;
    logic          r_out_pos, n_out_pos;
    logic          r_out_none, n_out_none;
    logic          r_out_bad, n_out_bad;
    logic          r_out_last, n_out_last;

    logic [SW-1:0]  w_side;
    logic [SW-1:0]  w_half;
    logic [SQW-1:0] w_sq;
    logic           w_out_free;
    logic           w_req_bad;

    logic          w_div_start;
    logic [IW-1:0] w_div_dvd;
    logic          w_div_done;
    logic [CW-1:0] w_div_quo;
    logic [CW-1:0] w_div_rem;

    logic [CW-1:0] w_pick_a, w_pick_b;
    logic [CW:0]   w_diff;
    logic          w_pick_dir;

    logic [CW-1:0] w_pos;
    logic [CW:0]   w_inc;
    logic [CW-1:0] w_nxt;
    logic [IW-1:0] w_next_base;

    always_comb begin
        w_side = (r_torus_side > txyr_pkg::CFG_W'(MAX_SIDE)) ? SW'(MAX_SIDE)
                                                             : r_torus_side[SW-1:0];
        w_half = w_side >> 1;
        w_sq   = SQW'(w_side) * SQW'(w_side);
        w_out_free = ~r_out_valid | o_hop.ready;
        w_req_bad  = (CMPW'(i_req.source_node) >= CMPW'(w_sq))
                   | (CMPW'(i_req.target_node) >= CMPW'(w_sq));
    end

    // shorter ring direction, positive on a tie when a < b
    always_comb begin
        if (r_state == txyr_pkg::ST_DIV_DST) begin
            w_pick_a = r_cur_col;
            w_pick_b = w_div_rem;
        end else begin
            w_pick_a = r_cur_row;
            w_pick_b = r_goal_row;
        end
        if (w_pick_a < w_pick_b) begin
            w_diff     = (CW+1)'(w_pick_b) - (CW+1)'(w_pick_a);
            w_pick_dir = ((SW+CW+1)'(w_diff) <= (SW+CW+1)'(w_half));
        end else begin
            w_diff     = (CW+1)'(w_pick_a) - (CW+1)'(w_pick_b);
            w_pick_dir = ~((SW+CW+1)'(w_diff) <= (SW+CW+1)'(w_half));
        end
    end

    // one ring step of the current coordinate
    always_comb begin
        w_pos = (r_state == txyr_pkg::ST_WALK_Y) ? r_cur_row : r_cur_col;
        w_inc = (CW+1)'(w_pos) + (CW+1)'(1);
        if (r_dir) begin
            w_nxt = (w_inc >= (CW+1)'(w_side)) ? '0 : w_inc[CW-1:0];
        end else begin
            w_nxt = (w_pos == '0) ? CW'(w_side - SW'(1)) : w_pos - CW'(1);
        end
        if (r_dir) begin
            w_next_base = (w_nxt == '0) ? '0 : r_base + IW'(w_side);
        end else begin
            w_next_base = (w_nxt == CW'(w_side - SW'(1))) ? IW'(w_sq - SQW'(w_side))
                                                           : r_base - IW'(w_side);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_dst       = r_dst;
        n_bad       = r_bad;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_goal_row  = r_goal_row;
        n_goal_col  = r_goal_col;
        n_dir       = r_dir;
        n_base      = r_base;
        n_out_valid = r_out_valid & ~o_hop.ready;
        n_out_from  = r_out_from;
        n_out_to    = r_out_to;
        n_out_dim   = r_out_dim;
        n_out_pos   = r_out_pos;
        n_out_none  = r_out_none;
        n_out_bad   = r_out_bad;
        n_out_last  = r_out_last;
        w_div_start = 1'b0;
        w_div_dvd   = r_dst;

        case (r_state)
            txyr_pkg::ST_IDLE: begin
                w_div_dvd = i_req.source_node;
                if (i_req.valid) begin
                    n_src = i_req.source_node;
                    n_dst = i_req.target_node;
                    n_bad = w_req_bad;
                    if (w_req_bad || (i_req.source_node == i_req.target_node)) begin
                        n_state = txyr_pkg::ST_SINGLE;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = txyr_pkg::ST_DIV_SRC;
                    end
                end
            end
            txyr_pkg::ST_SINGLE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_from  = r_src;
                    n_out_to    = r_bad ? r_dst : r_src;
                    n_out_dim   = 1'b0;
                    n_out_pos   = 1'b0;
                    n_out_none  = ~r_bad;
                    n_out_bad   = r_bad;
                    n_out_last  = 1'b1;
                    n_state     = txyr_pkg::ST_IDLE;
                end
            end
            txyr_pkg::ST_DIV_SRC: begin
                if (w_div_done) begin
                    n_cur_row   = w_div_quo;
                    n_cur_col   = w_div_rem;
                    n_base      = r_src - IW'(w_div_rem);
                    w_div_start = 1'b1;
                    n_state     = txyr_pkg::ST_DIV_DST;
                end
            end
            txyr_pkg::ST_DIV_DST: begin
                if (w_div_done) begin
                    n_goal_row = w_div_quo;
                    n_goal_col = w_div_rem;
                    n_dir      = w_pick_dir;
                    n_state    = txyr_pkg::ST_WALK_X;
                end
            end
            txyr_pkg::ST_WALK_X: begin
                if (r_cur_col == r_goal_col) begin
                    n_dir   = w_pick_dir;
                    n_state = txyr_pkg::ST_WALK_Y;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_from  = r_base + IW'(r_cur_col);
                    n_out_to    = r_base + IW'(w_nxt);
                    n_out_dim   = 1'b0;
                    n_out_pos   = r_dir;
                    n_out_none  = 1'b0;
                    n_out_bad   = 1'b0;
                    n_out_last  = (w_nxt == r_goal_col) && (r_cur_row == r_goal_row);
                    n_cur_col   = w_nxt;
                    if (n_out_last) begin
                        n_state = txyr_pkg::ST_IDLE;
                    end
                end
            end
            txyr_pkg::ST_WALK_Y: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_from  = r_base + IW'(r_goal_col);
                    n_out_to    = w_next_base + IW'(r_goal_col);
                    n_out_dim   = 1'b1;
                    n_out_pos   = r_dir;
                    n_out_none  = 1'b0;
                    n_out_bad   = 1'b0;
                    n_out_last  = (w_nxt == r_goal_row);
                    n_cur_row   = w_nxt;
                    n_base      = w_next_base;
                    if (n_out_last) begin
                        n_state = txyr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = txyr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= txyr_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_torus_side <= txyr_pkg::TORUS_SIDE_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_torus_side <= i_cfg.torus_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_bad      <= n_bad;
        r_cur_row  <= n_cur_row;
        r_cur_col  <= n_cur_col;
        r_goal_row <= n_goal_row;
        r_goal_col <= n_goal_col;
        r_dir      <= n_dir;
        r_base     <= n_base;
        r_out_from <= n_out_from;
        r_out_to   <= n_out_to;
        r_out_dim  <= n_out_dim;
        r_out_pos  <= n_out_pos;
        r_out_none <= n_out_none;
        r_out_bad  <= n_out_bad;
        r_out_last <= n_out_last;
    end

    txyr_divider #(
        .CW (CW),
        .SW (SW)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dvd),
        .i_divisor   (w_side),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == txyr_pkg::ST_IDLE);

    assign o_hop.valid        = r_out_valid;
    assign o_hop.hop_from     = r_out_from;
    assign o_hop.hop_to       = r_out_to;
    assign o_hop.hop_dim      = r_out_dim;
    assign o_hop.hop_positive = r_out_pos;
    assign o_hop.no_hop       = r_out_none;
    assign o_hop.bad_id       = r_out_bad;
    assign o_hop.last_hop     = r_out_last;

    `TXYR_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n,
        i_req.valid && i_req.ready, r_state != txyr_pkg::ST_IDLE)
    `TXYR_ASSERT_NOW(a_special_is_last, i_clk, i_rst_n,
        r_out_valid && (r_out_none || r_out_bad), r_out_last)
    `TXYR_ASSERT_NOW(a_hop_moves, i_clk, i_rst_n,
        r_out_valid && !r_out_none && !r_out_bad, r_out_from != r_out_to)
    `TXYR_ASSERT_NOW(a_div_done_in_split, i_clk, i_rst_n, w_div_done,
        (r_state == txyr_pkg::ST_DIV_SRC) || (r_state == txyr_pkg::ST_DIV_DST))

endmodule

FILE: test/torus_xy_route_hops_unit_test.sv
// Testbench for the torus XY route unit: random and directed routes checked against a hop predictor
`timescale 1ns / 1ps

typedef struct packed {
    logic [txyr_pkg::ID_W-1:0] hop_from;
    logic [txyr_pkg::ID_W-1:0] hop_to;
    logic                      hop_dim;
    logic                      hop_positive;
    logic                      no_hop;
    logic                      bad_id;
    logic                      last_hop;
} t_route_hop;

class route_scoreboard #(int MAX_SIDE = 32);
    logic [txyr_pkg::CFG_W-1:0] side_reg;
    t_route_hop                 hops_due[$];
    int unsigned                fail_count;

    function new();
        side_reg   = txyr_pkg::TORUS_SIDE_RST;
        fail_count = 0;
    endfunction

    function void set_side(logic [txyr_pkg::CFG_W-1:0] value);
        side_reg = value;
    endfunction

    function int unsigned effective_side();
        return (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
    endfunction

    function int unsigned pending();
        return hops_due.size();
    endfunction

    function logic go_positive(int unsigned from_c, int unsigned to_c, int unsigned half);
        if (from_c < to_c)
            return ((to_c - from_c) <= half);
        return !((from_c - to_c) <= half);
    endfunction

    function int unsigned ring_next(int unsigned pos, logic positive, int unsigned side);
        if (positive)
            return (pos + 1 >= side) ? 0 : pos + 1;
        return (pos == 0) ? side - 1 : pos - 1;
    endfunction

    function void note_request(logic [txyr_pkg::ID_W-1:0] src, logic [txyr_pkg::ID_W-1:0] dst);
        int unsigned side;
        int unsigned half;
        int unsigned cur_r;
        int unsigned cur_c;
        int unsigned goal_r;
        int unsigned goal_c;
        int unsigned nxt;
        int unsigned guard;
        logic        positive;
        t_route_hop  hop;
        t_route_hop  walk[$];
        side = effective_side();
        half = side / 2;
        hop  = '0;
        if (src >= side * side || dst >= side * side) begin
            hop.hop_from = src;
            hop.hop_to   = dst;
            hop.bad_id   = 1'b1;
            hop.last_hop = 1'b1;
            hops_due.push_back(hop);
            return;
        end
        if (src == dst) begin
            hop.hop_from = src;
            hop.hop_to   = src;
            hop.no_hop   = 1'b1;
            hop.last_hop = 1'b1;
            hops_due.push_back(hop);
            return;
        end
        cur_r  = src / side;
        cur_c  = src % side;
        goal_r = dst / side;
        goal_c = dst % side;
        // walk X along the source row
        positive = go_positive(cur_c, goal_c, half);
        guard    = 0;
        while (cur_c != goal_c && guard < MAX_SIDE && walk.size() < 32) begin
            nxt              = ring_next(cur_c, positive, side);
            hop              = '0;
            hop.hop_from     = txyr_pkg::ID_W'(cur_r * side + cur_c);
            hop.hop_to       = txyr_pkg::ID_W'(cur_r * side + nxt);
            hop.hop_positive = positive;
            walk.push_back(hop);
            cur_c = nxt;
            guard++;
        end
        // walk Y along the target column
        positive = go_positive(cur_r, goal_r, half);
        guard    = 0;
        while (cur_r != goal_r && guard < MAX_SIDE && walk.size() < 32) begin
            nxt              = ring_next(cur_r, positive, side);
            hop              = '0;
            hop.hop_from     = txyr_pkg::ID_W'(cur_r * side + goal_c);
            hop.hop_to       = txyr_pkg::ID_W'(nxt * side + goal_c);
            hop.hop_dim      = 1'b1;
            hop.hop_positive = positive;
            walk.push_back(hop);
            cur_r = nxt;
            guard++;
        end
        foreach (walk[i]) begin
            hop          = walk[i];
            hop.last_hop = (i == walk.size() - 1);
            hops_due.push_back(hop);
        end
    endfunction

    function void compare_field(string name, logic [txyr_pkg::ID_W-1:0] exp_v,
                                logic [txyr_pkg::ID_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function void check_hop(t_route_hop got);
        t_route_hop want;
        if (hops_due.size() == 0) begin
            $error("hop transaction %0d -> %0d with no route pending", got.hop_from, got.hop_to);
            fail_count++;
            return;
        end
        want = hops_due.pop_front();
        compare_field("hop_from", want.hop_from, got.hop_from);
        compare_field("hop_to", want.hop_to, got.hop_to);
        compare_field("hop_dim", txyr_pkg::ID_W'(want.hop_dim),
                      txyr_pkg::ID_W'(got.hop_dim));
        compare_field("hop_positive", txyr_pkg::ID_W'(want.hop_positive),
                      txyr_pkg::ID_W'(got.hop_positive));
        compare_field("no_hop", txyr_pkg::ID_W'(want.no_hop),
                      txyr_pkg::ID_W'(got.no_hop));
        compare_field("bad_id", txyr_pkg::ID_W'(want.bad_id),
                      txyr_pkg::ID_W'(got.bad_id));
        compare_field("last_hop", txyr_pkg::ID_W'(want.last_hop),
                      txyr_pkg::ID_W'(got.last_hop));
    endfunction

    function void flush_leftover();
        if (hops_due.size() != 0) begin
            $error("%0d hop transactions never arrived", hops_due.size());
            fail_count++;
        end
    endfunction
endclass

module torus_xy_route_hops_unit_test;

    localparam int          MAX_SIDE         = 32;
    localparam int unsigned ROUTES_PER_PHASE = 33;
    localparam int unsigned DRAIN_LIMIT      = 50000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    txyr_cfg_if side_cfg();
    txyr_req_if route_req();
    txyr_hop_if route_hop();

    route_scoreboard #(MAX_SIDE) sb;
    t_route_hop                  seen_hop;
    int unsigned                 burst_left = 0;

    int unsigned side_plan[12] = '{1, 0, 2, 3, 63, 5, 16, 31, 8, 33, 7, 32};

    torus_xy_route_hops_unit #(
        .MAX_SIDE(MAX_SIDE)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (side_cfg),
        .i_req  (route_req),
        .o_hop  (route_hop)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_route(input logic [txyr_pkg::ID_W-1:0] src,
                              input logic [txyr_pkg::ID_W-1:0] dst);
        int unsigned gap;
        if (burst_left == 0) begin
            route_req.valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        route_req.valid       <= 1'b1;
        route_req.source_node <= src;
        route_req.target_node <= dst;
        do @(posedge i_clk); while (!route_req.ready);
        sb.note_request(src, dst);
        burst_left--;
    endtask

    task automatic set_side(input logic [txyr_pkg::CFG_W-1:0] value);
        route_req.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        side_cfg.valid      <= 1'b1;
        side_cfg.torus_side <= value;
        do @(posedge i_clk); while (!side_cfg.ready);
        side_cfg.valid <= 1'b0;
        sb.set_side(value);
    endtask

    function automatic logic [txyr_pkg::ID_W-1:0] pick_id(int unsigned span);
        if (span == 0)
            return txyr_pkg::ID_W'($urandom_range(0, 1023));
        return txyr_pkg::ID_W'($urandom_range(0, span - 1));
    endfunction

    task automatic random_routes(input int unsigned count);
        int unsigned                side;
        int unsigned                span;
        int unsigned                kind;
        logic [txyr_pkg::ID_W-1:0]  src;
        logic [txyr_pkg::ID_W-1:0]  dst;
        side = sb.effective_side();
        span = side * side;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            src  = pick_id(span);
            dst  = pick_id(span);
            if (kind < 8) begin
                dst = src;
            end else if (kind < 18) begin
                src = txyr_pkg::ID_W'($urandom_range(0, 1023));
                dst = txyr_pkg::ID_W'($urandom_range(0, 1023));
            end else if (kind < 26 && side != 0) begin
                // same row: X only
                dst = txyr_pkg::ID_W'((src / side) * side + $urandom_range(0, side - 1));
            end else if (kind < 34 && side != 0) begin
                // same column: Y only
                dst = txyr_pkg::ID_W'($urandom_range(0, side - 1) * side + src % side);
            end
            send_route(src, dst);
        end
    endtask

    // receiver stall pattern
    initial begin
        t_stall_mode mode;
        int unsigned seg_left;
        int unsigned tick;
        mode     = STALL_NONE;
        seg_left = 0;
        tick     = 0;
        route_hop.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (seg_left == 0) begin
                mode     = t_stall_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(4, 40);
            end
            seg_left--;
            case (mode)
                STALL_NONE:     route_hop.ready <= 1'b1;
                STALL_LIGHT:    route_hop.ready <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: route_hop.ready <= (tick % 3 != 0);
                default:        route_hop.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && route_hop.valid && route_hop.ready) begin
            seen_hop.hop_from     = route_hop.hop_from;
            seen_hop.hop_to       = route_hop.hop_to;
            seen_hop.hop_dim      = route_hop.hop_dim;
            seen_hop.hop_positive = route_hop.hop_positive;
            seen_hop.no_hop       = route_hop.no_hop;
            seen_hop.bad_id       = route_hop.bad_id;
            seen_hop.last_hop     = route_hop.last_hop;
            sb.check_hop(seen_hop);
        end
    end

    initial begin
        int unsigned waited;
        sb = new();
        i_rst_n               <= 1'b0;
        side_cfg.valid        <= 1'b0;
        side_cfg.torus_side   <= '0;
        route_req.valid       <= 1'b0;
        route_req.source_node <= '0;
        route_req.target_node <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset side of 4
        send_route(10'd0, 10'd0);
        send_route(10'd0, 10'd15);
        send_route(10'd15, 10'd0);
        send_route(10'd0, 10'd2);
        send_route(10'd2, 10'd0);
        send_route(10'd0, 10'd8);
        send_route(10'd8, 10'd0);
        send_route(10'd5, 10'd7);
        send_route(10'd16, 10'd0);
        send_route(10'd0, 10'd16);
        send_route(10'd1023, 10'd1023);
        send_route(10'd1023, 10'd0);

        set_side(6'd32);
        send_route(10'd0, 10'd1023);
        send_route(10'd1023, 10'd0);
        send_route(10'd0, 10'd16);
        send_route(10'd16, 10'd0);
        send_route(10'd0, 10'd512);
        send_route(10'd512, 10'd0);
        send_route(10'd1023, 10'd1023);
        send_route(10'd341, 10'd682);
        send_route(10'd682, 10'd341);
        send_route(10'd31, 10'd32);
        send_route(10'd32, 10'd31);

        foreach (side_plan[p]) begin
            set_side(txyr_pkg::CFG_W'(side_plan[p]));
            random_routes(ROUTES_PER_PHASE);
        end
        repeat (2) begin
            set_side(txyr_pkg::CFG_W'($urandom_range(1, 32)));
            random_routes(ROUTES_PER_PHASE);
        end
        route_req.valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        sb.flush_leftover();
        if (sb.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
